// ===== hw/rtl/lru_pkg.sv =====
`default_nettype none

package lru_pkg;

    // list geometry
    localparam int SLOTS        = 16;
    localparam int PAGE_ID_BITS = 8;
    localparam int IDX_W        = $clog2(SLOTS);
    localparam int CNT_W        = $clog2(SLOTS + 1);

    // fixed field widths on the ports
    localparam int PAGE_W   = 8;
    localparam int STATUS_W = 2;

    typedef logic [PAGE_ID_BITS-1:0] page_t;

    // action codes
    localparam logic ACT_TOUCH = 1'b0;
    localparam logic ACT_EVICT = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_TOUCHED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_VICTIM  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_SEARCH,
        CTL_UPDATE
    } lru_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture the incoming item
        logic search;  // register the match vector
        logic commit;  // update list and load result register
    } lru_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // result register can take a new result this cycle
    } lru_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lru_ctrl.sv =====
`default_nettype none

module lru_ctrl
    import lru_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire lru_stat_t stat,
    output lru_cmd_t       cmd
);

    lru_state_t state_reg;
    lru_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CTL_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = CTL_SEARCH;
                end
            end
            CTL_SEARCH:
            begin
                state_next = CTL_UPDATE;
            end
            CTL_UPDATE:
            begin
                // wait here while the previous result is still unclaimed
                if (stat.out_free)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.search = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            CTL_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            CTL_SEARCH:
            begin
                cmd.search = 1'b1;
            end
            CTL_UPDATE:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lru_datapath.sv =====
`default_nettype none

module lru_datapath
    import lru_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lru_cmd_t            cmd,
    output lru_stat_t                stat,
    input  wire logic                in_action,
    input  wire logic [PAGE_W-1:0]   in_page,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      out_status,
    output logic [PAGE_W-1:0]        out_victim
);

    // list storage: entry 0 is least recent
    page_t              list_reg [SLOTS];
    page_t              entries_next [SLOTS];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // captured item
    logic               action_reg;
    page_t              page_reg;

    // one-hot (or zero) position of the touched page; the list holds no duplicates
    logic [SLOTS-1:0]   match_reg;
    logic [SLOTS-1:0]   match_next;

    // result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [PAGE_W-1:0]   out_victim_reg;
    logic [STATUS_W-1:0] status_next;
    logic [PAGE_W-1:0]   victim_next;

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_victim    = out_victim_reg;

    // parallel compare against the live entries
    always_comb
    begin
        for (int k = 0; k < SLOTS; k++)
        begin
            match_next[k] = (CNT_W'(k) < count_reg) && (list_reg[k] == page_reg);
        end
    end

    // list update: close the gap at the removed entry, then append at the tail
    always_comb
    begin
        logic [SLOTS-1:0] remove;
        logic             found;
        logic             seen;
        logic             wr_en;
        logic [CNT_W-1:0] cnt_after;

        remove      = '0;
        seen        = 1'b0;
        found       = |match_reg;
        wr_en       = 1'b0;
        cnt_after   = count_reg;
        count_next  = count_reg;
        status_next = ST_TOUCHED;
        victim_next = '0;

        if (action_reg == ACT_EVICT)
        begin
            if (count_reg == '0)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next = ST_VICTIM;
                victim_next = PAGE_W'(list_reg[0]);
                remove      = '1;
                count_next  = count_reg - CNT_W'(1);
            end
        end
        else
        begin
            // entries at and above the hit slide down by one
            for (int k = 0; k < SLOTS; k++)
            begin
                seen      = seen | match_reg[k];
                remove[k] = seen;
            end
            if (found)
            begin
                cnt_after = count_reg - CNT_W'(1);
            end
            if (cnt_after == CNT_W'(SLOTS))
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_TOUCHED;
                wr_en       = 1'b1;
                count_next  = cnt_after + CNT_W'(1);
            end
        end

        for (int k = 0; k < SLOTS; k++)
        begin
            if (wr_en && (cnt_after == CNT_W'(k)))
            begin
                entries_next[k] = page_reg;
            end
            else if (remove[k] && (k + 1 < SLOTS))
            begin
                entries_next[k] = list_reg[(k + 1) % SLOTS];
            end
            else
            begin
                entries_next[k] = list_reg[k];
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= in_action;
            page_reg   <= PAGE_ID_BITS'(in_page);
        end
        if (cmd.search)
        begin
            match_reg <= match_next;
        end
        if (cmd.commit)
        begin
            list_reg       <= entries_next;
            out_status_reg <= status_next;
            out_victim_reg <= victim_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lru_page_replacement_top.sv =====
`default_nettype none

// LRU replacement list for up to SLOTS page ids, least recent first.
//
// Input stream (s_axis): one item per request. tuser = action (touch or
// evict), tdata = page id. A touch moves the page to the most-recent end,
// adding it if absent unless the list is full; an evict pops the least
// recently used page. Output stream (m_axis): exactly one result item per
// input item, in order. tuser = status (touched, victim, empty, full),
// tdata = victim page id, zero unless the status is victim.
//
// Timing: an accepted item is searched in the next cycle (parallel compare
// of all live entries into a match register) and then committed, loading
// the result register, which presents the result. A new item is accepted
// only after the previous one is committed, set by the accept/search/commit
// sequence of the controller. The output register lets the next item be
// accepted and searched while the previous result waits.
// Stalls: if m_axis_tready stays low, the commit waits until the result
// register frees up, and input acceptance stops behind it.
// Reset (rst_n low, async): list empty, no result pending, controller idle.

module lru_page_replacement_top
    import lru_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,   // [7:0] page_id
    input  wire logic [0:0]          s_axis_tuser,   // [0] action
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [7:0]               m_axis_tdata,   // [7:0] victim_page
    output logic [1:0]               m_axis_tuser    // [1:0] status
);

    // List contents are not cleared at reset; only entries below the count
    // are ever read.

    lru_cmd_t  cmd;
    lru_stat_t stat;

    lru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lru_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_action  (s_axis_tuser[0]),
        .in_page    (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_victim (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== tb/sv/lru_page_replacement_top_tb.sv =====
`default_nettype none

module lru_page_replacement_top_tb;
    import lru_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int RAND_ITEMS  = 550;
    localparam int DIR_N       = 27;

    // one result item: status code plus victim page
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   victim;
    } lru_result_t;

    // directed row; typed rows carry the expected result inline
    typedef struct {
        logic                act;
        logic [PAGE_W-1:0]   page;
        bit                  typed;
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   victim;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;   // [7:0] page_id
    logic [0:0]        s_axis_tuser;   // [0] action
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;   // [7:0] victim_page
    logic [1:0]        m_axis_tuser;   // [1:0] status

    // shadow copy of the recency list, least recent at index 0
    page_t             shadow_pages [SLOTS];
    int                shadow_count;

    lru_result_t       pending_results [$];
    int                fail_count;
    int                cycle_count;
    int                status_seen [4];
    int                items_sent;
    bit                steady;          // both sides stop idling while set

    stim_row_t dir_rows [DIR_N] = '{
        // reset: evict on an empty list
        '{ACT_EVICT, 8'h00, 1'b1, ST_EMPTY,   8'h00},
        // extremes of page id, second touch of the same page
        '{ACT_TOUCH, 8'h00, 1'b1, ST_TOUCHED, 8'h00},
        '{ACT_TOUCH, 8'hFF, 1'b1, ST_TOUCHED, 8'h00},
        '{ACT_TOUCH, 8'hFF, 1'b1, ST_TOUCHED, 8'h00},
        // evict ignores the page field
        '{ACT_EVICT, 8'hFF, 1'b1, ST_VICTIM,  8'h00},
        '{ACT_EVICT, 8'h00, 1'b1, ST_VICTIM,  8'hFF},
        '{ACT_EVICT, 8'hA5, 1'b1, ST_EMPTY,   8'h00},
        // fill all slots, walking ones and zeros through the page id
        '{ACT_TOUCH, 8'h01, 1'b0, ST_TOUCHED, 8'h00},
        '{ACT_TOUCH, 8'h02, 1'b0, ST_TOUCHED, 8'h00},
        '{ACT_TOUCH, 8'h04, 1'b0, ST_TOUCHED, 8'h00},
        '{ACT_TOUCH, 8'h08, 1'b0, ST_TOUCHED, 8'h00},
        '{ACT_TOUCH, 8'h10, 1'b0, ST_TOUCHED, 8'h00},
        '{ACT_TOUCH, 8'h20, 1'b0, ST_TOUCHED, 8'h00},
        '{ACT_TOUCH, 8'h40, 1'b0, ST_TOUCHED, 8'h00},
        '{ACT_TOUCH, 8'h80, 1'b0, ST_TOUCHED, 8'h00},
        '{ACT_TOUCH, 8'hFE, 1'b0, ST_TOUCHED, 8'h00},
        '{ACT_TOUCH, 8'hFD, 1'b0, ST_TOUCHED, 8'h00},
        '{ACT_TOUCH, 8'hFB, 1'b0, ST_TOUCHED, 8'h00},
        '{ACT_TOUCH, 8'hF7, 1'b0, ST_TOUCHED, 8'h00},
        '{ACT_TOUCH, 8'hEF, 1'b0, ST_TOUCHED, 8'h00},
        '{ACT_TOUCH, 8'hDF, 1'b0, ST_TOUCHED, 8'h00},
        '{ACT_TOUCH, 8'hBF, 1'b0, ST_TOUCHED, 8'h00},
        '{ACT_TOUCH, 8'h7F, 1'b0, ST_TOUCHED, 8'h00},
        // new page on a full list is dropped
        '{ACT_TOUCH, 8'h33, 1'b1, ST_FULL,    8'h00},
        // present page on a full list still moves to the recent end
        '{ACT_TOUCH, 8'h04, 1'b1, ST_TOUCHED, 8'h00},
        '{ACT_EVICT, 8'h00, 1'b1, ST_VICTIM,  8'h01},
        '{ACT_TOUCH, 8'h33, 1'b0, ST_TOUCHED, 8'h00}
    };

    lru_page_replacement_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // close the gap left by the entry at pos
    function automatic void shadow_remove(input int pos);
        for (int k = pos; k + 1 < shadow_count; k++)
            shadow_pages[k] = shadow_pages[k + 1];
        shadow_count--;
    endfunction

    // apply one item to the shadow list and return the result it gives
    function automatic lru_result_t lru_apply(input logic act,
                                              input logic [PAGE_W-1:0] page_in);
        lru_result_t r;
        page_t       pg;
        int          hit;
        r.status = ST_TOUCHED;
        r.victim = '0;
        pg       = page_t'(page_in);
        hit      = -1;
        if (act == ACT_EVICT)
        begin
            if (shadow_count == 0)
                r.status = ST_EMPTY;
            else
            begin
                r.status = ST_VICTIM;
                r.victim = PAGE_W'(shadow_pages[0]);
                shadow_remove(0);
            end
        end
        else
        begin
            for (int k = 0; k < shadow_count; k++)
                if (hit < 0 && shadow_pages[k] == pg)
                    hit = k;
            if (hit >= 0)
                shadow_remove(hit);
            if (shadow_count >= SLOTS)
                r.status = ST_FULL;
            else
            begin
                shadow_pages[shadow_count] = pg;
                shadow_count++;
            end
        end
        return r;
    endfunction

    // drive one item, wait for accept, queue its expected result
    task automatic send_item(input logic act, input logic [PAGE_W-1:0] page,
                             input bit typed, input lru_result_t typed_res);
        lru_result_t r;
        while (!steady && $urandom_range(0, 99) < 29)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= page;
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = lru_apply(act, page);
        if (typed)
            r = typed_res;
        pending_results.push_back(r);
        items_sent++;
    endtask

    // sink side backpressure
    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 29);

    // result checker
    always @(posedge clk)
    begin
        lru_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            status_seen[m_axis_tuser]++;
            if (pending_results.size() == 0)
            begin
                $error("result item with nothing expected: status %0d victim_page %0h",
                       m_axis_tuser, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (m_axis_tuser !== e.status)
                begin
                    $error("status mismatch: expected %0d, got %0d", e.status, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata !== e.victim)
                begin
                    $error("victim_page mismatch: expected %0h, got %0h",
                           e.victim, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        lru_result_t tr;
        logic        act;
        logic [7:0]  page;
        int          evict_pct;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_TOUCH;
        steady        <= 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        items_sent    = 0;
        shadow_count  = 0;
        foreach (shadow_pages[i])
            shadow_pages[i] = '0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
        begin
            tr.status = dir_rows[i].status;
            tr.victim = dir_rows[i].victim;
            send_item(dir_rows[i].act, dir_rows[i].page, dir_rows[i].typed, tr);
        end

        // random part: fill-heavy, balanced, drain-heavy, then mixed phases
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == 180)
                steady <= 1'b1;
            if (n == 280)
                steady <= 1'b0;
            if (n == 350)
            begin
                // hold off until the block has answered everything
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            if (n < 140)
                evict_pct = 15;
            else if (n < 260)
                evict_pct = 40;
            else if (n < 350)
                evict_pct = 65;
            else
                evict_pct = (n / 50) % 2 ? 20 : 45;
            act = ($urandom_range(0, 99) < evict_pct) ? ACT_EVICT : ACT_TOUCH;
            // mostly a small working set so hits and full drops are frequent
            if ($urandom_range(0, 99) < 75)
                page = 8'($urandom_range(0, 21)) ^ 8'hA0;
            else
                page = 8'($urandom);
            tr.status = ST_TOUCHED;
            tr.victim = '0;
            send_item(act, page, 1'b0, tr);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end

        $display("Sent %0d items (directed table plus random touch/evict phases).", items_sent);
        $display("Results seen: touched %0d, victim %0d, empty %0d, full %0d.",
                 status_seen[ST_TOUCHED], status_seen[ST_VICTIM],
                 status_seen[ST_EMPTY], status_seen[ST_FULL]);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
